// ===== rtl/itad_pkg.sv =====
// Package with the item types, format codes, state types and character helper.
package itad_pkg;

    // Widths of the value, the digit register and the character count.
    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;
    localparam int NDEC    = 10;
    localparam int NHEX    = VALUE_W / DIGIT_W;
    localparam int DIGS_W  = NDEC * DIGIT_W;
    localparam int COUNT_W = 31;
    localparam int BITCNT_W = $clog2(VALUE_W);
    localparam int NDIG_W  = $clog2(NDEC + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // ASCII codes used when building characters.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // Format selector codes.
    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_HEXL = 2'd2,
        OP_HEXU = 2'd3
    } op_t;

    // Input item.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         op;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [7:0]         character;
        logic               last;
        logic [COUNT_W-1:0] total_count;
    } out_t;

    // Digit string handed from the front end to the character emitter.
    typedef struct packed {
        logic                valid;
        logic [DIGS_W-1:0]   digits;
        logic [NDIG_W-1:0]   ndig;
        logic                neg;
        logic                upper;
    } emit_load_t;

    // Front-end sequencer states.
    typedef enum logic {
        TS_IDLE,
        TS_CONV
    } top_state_t;

    // Emitter states.
    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SKIP,
        EM_SEND
    } emit_state_t;

    // ASCII code of one decimal or hexadecimal digit.
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {{(8-DIGIT_W){1'b0}}, d};
        if (d8 < 8'd10) begin
            return CHAR_ZERO + d8;
        end
        return (upper ? CHAR_UA : CHAR_LA) + d8 - 8'd10;
    endfunction

endpackage

// ===== rtl/itad_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add-three), one bit per cycle.
module itad_bcd (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [itad_pkg::VALUE_W-1:0]   mag,
    output logic                           done,
    output logic [itad_pkg::DIGS_W-1:0]    bcd
);
    import itad_pkg::*;

    logic [VALUE_W-1:0]  bin_reg;
    logic [DIGS_W-1:0]   bcd_reg;
    logic [DIGS_W-1:0]   adj;
    logic [BITCNT_W-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    // Add three to every digit of five or more before the next shift.
    always_comb begin
        for (int i = 0; i < NDEC; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Control: count the input bits as they shift and raise done after the last.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == BITCNT_W'(VALUE_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == BITCNT_W'(VALUE_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: binary bits shift out the top into the digit register.
    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= mag;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {adj[DIGS_W-2:0], bin_reg[VALUE_W-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== rtl/itad_emit.sv =====
// Character emitter: drops leading zeros and sends the sign and digits one character at a time.
module itad_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  itad_pkg::emit_load_t load,
    output logic                 busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output itad_pkg::out_t       m_data
);
    import itad_pkg::*;

    emit_state_t         state_reg, state_next;
    logic [DIGS_W-1:0]   digits_reg, digits_next;
    logic [NDIG_W-1:0]   rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic                upper_reg, upper_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;
    logic                out_free;
    logic [DIGIT_W-1:0]  top_digit;

    assign out_free  = !m_valid_reg || m_ready;
    assign top_digit = digits_reg[DIGS_W-1 -: DIGIT_W];

    // State register and control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EM_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Digit string and output payload.
    always_ff @(posedge aclk) begin
        digits_reg <= digits_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        upper_reg  <= upper_next;
        m_data_reg <= m_data_next;
    end

    // Next state: load, skip leading zeros, then send one character at a time.
    always_comb begin
        state_next   = state_reg;
        digits_next  = digits_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        upper_next   = upper_reg;
        cnt_next     = cnt_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            EM_IDLE: begin
                if (load.valid) begin
                    digits_next = load.digits;
                    rem_next    = load.ndig;
                    neg_next    = load.neg;
                    upper_next  = load.upper;
                    state_next  = EM_SKIP;
                end
            end
            EM_SKIP: begin
                if (top_digit == '0 && rem_reg > NDIG_W'(1)) begin
                    digits_next = {digits_reg[DIGS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    rem_next    = rem_reg - 1'b1;
                end else begin
                    state_next = EM_SEND;
                end
            end
            EM_SEND: begin
                if (out_free) begin
                    cnt_next                = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
                    m_valid_next            = 1'b1;
                    m_data_next.total_count = cnt_next;
                    if (neg_reg) begin
                        m_data_next.character = CHAR_MINUS;
                        m_data_next.last      = 1'b0;
                        neg_next              = 1'b0;
                    end else begin
                        m_data_next.character = digit_char(top_digit, upper_reg);
                        m_data_next.last      = (rem_reg == NDIG_W'(1));
                        digits_next = {digits_reg[DIGS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        rem_next    = rem_reg - 1'b1;
                        if (rem_reg == NDIG_W'(1)) begin
                            state_next = EM_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != EM_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // A new digit string only arrives while the emitter is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load.valid |-> state_reg == EM_IDLE)
        else $error("digit string loaded while emitter busy");

    // Work in progress always has at least one digit left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EM_SKIP || state_reg == EM_SEND) |-> rem_reg != '0)
        else $error("emitter running with no digits left");

    // The running count never goes down.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> cnt_reg >= $past(cnt_reg))
        else $error("character count decreased");
`endif

endmodule

// ===== rtl/integer_to_ascii_digits.sv =====
// Top level: integer to signed/unsigned decimal or hex ASCII character stream.
//
//   Channel  Ports                      Item                       Direction
//   s_       s_valid s_ready s_data     value, op                  in
//   m_       m_valid m_ready m_data     character, last, count     out
//
// Decimal: accept, run the bit-serial converter, load, skip leading zeros, then send the
// characters, a minus sign first if negative. A new item waits until the emitter is idle.
// Hex skips the converter: accept and load, skip leading zeros, then send the characters.
// Synchronous active-low reset clears the count and all control state.
// A stalled m_ready holds the current character and pauses the emitter.
module integer_to_ascii_digits (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  itad_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output itad_pkg::out_t m_data
);
    import itad_pkg::*;

    top_state_t          state_reg, state_next;
    logic                neg_reg, neg_next;
    logic                s_fire;
    logic                is_hex;
    logic                is_neg;
    logic [VALUE_W-1:0]  mag;
    logic                bcd_start;
    logic                bcd_done;
    logic [DIGS_W-1:0]   bcd;
    logic                emit_busy;
    emit_load_t          load;

    assign s_fire = s_valid && s_ready;
    assign is_hex = (s_data.op == OP_HEXL) || (s_data.op == OP_HEXU);
    assign is_neg = (s_data.op == OP_SDEC) && s_data.value[VALUE_W-1];
    assign mag    = is_neg ? (VALUE_W'(0) - s_data.value) : s_data.value;

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
    end

    // Next state: hex goes straight to the emitter, decimal through the converter.
    always_comb begin
        state_next = state_reg;
        neg_next   = neg_reg;
        s_ready    = 1'b0;
        bcd_start  = 1'b0;
        load       = '0;
        unique case (state_reg)
            TS_IDLE: begin
                s_ready = !emit_busy;
                if (s_fire) begin
                    if (is_hex) begin
                        load.valid  = 1'b1;
                        load.digits = {s_data.value, {(DIGS_W-VALUE_W){1'b0}}};
                        load.ndig   = NDIG_W'(NHEX);
                        load.neg    = 1'b0;
                        load.upper  = (s_data.op == OP_HEXU);
                    end else begin
                        bcd_start  = 1'b1;
                        neg_next   = is_neg;
                        state_next = TS_CONV;
                    end
                end
            end
            TS_CONV: begin
                if (bcd_done) begin
                    load.valid  = 1'b1;
                    load.digits = bcd;
                    load.ndig   = NDIG_W'(NDEC);
                    load.neg    = neg_reg;
                    load.upper  = 1'b0;
                    state_next  = TS_IDLE;
                end
            end
            default: begin
                state_next = TS_IDLE;
            end
        endcase
    end

    itad_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .mag     (mag),
        .done    (bcd_done),
        .bcd     (bcd)
    );

    itad_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .busy    (emit_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
